// ===== hdl/jsu_pkg.sv =====
// shared types, escape codes and hex digit decode for the json string unescaper
package jsu_pkg;

    typedef enum logic [5:0] {
        PH_PLAIN = 6'b000001,
        PH_ESC   = 6'b000010,
        PH_HEX1  = 6'b000100,
        PH_HEX2  = 6'b001000,
        PH_HEX3  = 6'b010000,
        PH_HEX4  = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [15:0] unit;
        logic [15:0] length;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    localparam logic [15:0] CU_NUL       = 16'h0000;
    localparam logic [15:0] CU_QUOTE     = 16'h0022;
    localparam logic [15:0] CU_BACKSLASH = 16'h005C;
    localparam logic [15:0] CU_SLASH     = 16'h002F;
    localparam logic [15:0] CU_LOWER_B   = 16'h0062;
    localparam logic [15:0] CU_LOWER_F   = 16'h0066;
    localparam logic [15:0] CU_LOWER_N   = 16'h006E;
    localparam logic [15:0] CU_LOWER_R   = 16'h0072;
    localparam logic [15:0] CU_LOWER_T   = 16'h0074;
    localparam logic [15:0] CU_LOWER_U   = 16'h0075;
    localparam logic [15:0] CU_BS        = 16'h0008;
    localparam logic [15:0] CU_FF        = 16'h000C;
    localparam logic [15:0] CU_LF        = 16'h000A;
    localparam logic [15:0] CU_CR        = 16'h000D;
    localparam logic [15:0] CU_TAB       = 16'h0009;

    function automatic hex_digit_t hex_digit(input logic [15:0] c);
        hex_digit_t d;
        d.ok    = 1'b1;
        d.value = 4'd0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            d.value = 4'(c - 16'h0030);
        end else if (c >= 16'h0041 && c <= 16'h0046) begin
            d.value = 4'(c - 16'h0037);
        end else if (c >= 16'h0061 && c <= 16'h0066) begin
            d.value = 4'(c - 16'h0057);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== hdl/json_string_unescaper.sv =====
// top level of the json string unescaper: input register, decode step, result register
//
//  channel  | dir | ports                                        | beat
//  s_       | in  | s_valid s_ready s_code_unit                  | one code unit
//  m_       | out | m_valid m_ready m_kind m_decoded_unit ...   | char, end or error
//
// one beat per cycle sustained while the result register is not stalled.
// the decode step sits between the input register and the result register.
// reset (aresetn low, synchronous) empties both registers and returns to plain text.
// a stalled result register stops the input register, which then stops s_ready;
// beats that give no result still wait for the result register to drain.
module json_string_unescaper
    import jsu_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_decoded_unit,
    output logic [15:0] m_decoded_length
);

    logic                   in_valid_reg, in_valid_next;
    logic [15:0]            in_unit_reg;
    phase_t                 phase_reg, phase_next;
    logic [15:0]            hex_reg, hex_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg;
    result_t                step_res;
    logic                   consume;

    assign consume = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || consume;

    jsu_step #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_step (
        .phase_i    (phase_reg),
        .hex_i      (hex_reg),
        .count_i    (count_reg),
        .code_unit_i(in_unit_reg),
        .phase_o    (phase_next),
        .hex_o      (hex_next),
        .count_o    (count_next),
        .result_o   (step_res)
    );

    always_comb begin
        in_valid_next = s_ready ? s_valid : in_valid_reg;
        if (consume && step_res.valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_PLAIN;
            hex_reg       <= 16'd0;
            count_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (consume) begin
                phase_reg <= phase_next;
                hex_reg   <= hex_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_unit_reg <= s_code_unit;
        end
        if (consume && step_res.valid) begin
            out_reg <= step_res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_reg.kind;
    assign m_decoded_unit   = out_reg.unit;
    assign m_decoded_length = out_reg.length;

    // end or error leaves the decoder at the start of a fresh string
    assert property (@(posedge aclk) disable iff (!aresetn)
        consume && step_res.valid && step_res.kind != KIND_CHAR
        |=> phase_reg == PH_PLAIN && count_reg == '0 && hex_reg == 16'd0)
        else $error("decoder not restarted after end or error");

    // input side only stalls behind a full, stalled result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without downstream backpressure");

    // a unicode escape opener clears the hex accumulator
    assert property (@(posedge aclk) disable iff (!aresetn)
        consume && phase_reg == PH_ESC && in_unit_reg == CU_LOWER_U
        |=> phase_reg == PH_HEX1 && hex_reg == 16'd0 && !out_valid_reg)
        else $error("unicode escape not started correctly");

    // only end beats carry a length, only char beats carry a unit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind == KIND_END || m_decoded_length == 16'd0)
                 && (m_kind == KIND_CHAR || m_decoded_unit == 16'd0))
        else $error("result fields inconsistent with kind");

endmodule

// ===== hdl/jsu_step.sv =====
// one decode step: next state and result for a single code unit
module jsu_step
    import jsu_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  phase_t                 phase_i,
    input  logic [15:0]            hex_i,
    input  logic [LENGTH_BITS-1:0] count_i,
    input  logic [15:0]            code_unit_i,
    output phase_t                 phase_o,
    output logic [15:0]            hex_o,
    output logic [LENGTH_BITS-1:0] count_o,
    output result_t                result_o
);

    logic [LENGTH_BITS-1:0] count_inc;
    logic [31:0]            count_wide;
    logic [15:0]            count_sat;
    logic [15:0]            hex_shift;
    hex_digit_t             digit;

    assign count_inc  = (count_i == {LENGTH_BITS{1'b1}}) ? count_i : count_i + 1'b1;
    assign count_wide = 32'(count_i);
    assign count_sat  = (|count_wide[31:16]) ? 16'hFFFF : count_wide[15:0];
    assign digit      = hex_digit(code_unit_i);
    assign hex_shift  = {hex_i[11:0], digit.value};

    always_comb begin
        phase_o         = phase_i;
        hex_o           = hex_i;
        count_o         = count_i;
        result_o.valid  = 1'b0;
        result_o.kind   = KIND_CHAR;
        result_o.unit   = 16'd0;
        result_o.length = 16'd0;
        unique case (phase_i)
            PH_ESC: begin
                phase_o        = PH_PLAIN;
                result_o.valid = 1'b1;
                count_o        = count_inc;
                priority case (code_unit_i)
                    CU_QUOTE:     result_o.unit = CU_QUOTE;
                    CU_BACKSLASH: result_o.unit = CU_BACKSLASH;
                    CU_SLASH:     result_o.unit = CU_SLASH;
                    CU_LOWER_B:   result_o.unit = CU_BS;
                    CU_LOWER_F:   result_o.unit = CU_FF;
                    CU_LOWER_N:   result_o.unit = CU_LF;
                    CU_LOWER_R:   result_o.unit = CU_CR;
                    CU_LOWER_T:   result_o.unit = CU_TAB;
                    CU_LOWER_U: begin
                        phase_o        = PH_HEX1;
                        hex_o          = 16'd0;
                        count_o        = count_i;
                        result_o.valid = 1'b0;
                    end
                    default: begin
                        hex_o         = 16'd0;
                        count_o       = '0;
                        result_o.kind = KIND_ERR;
                    end
                endcase
            end
            PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
                priority if (!digit.ok) begin
                    phase_o        = PH_PLAIN;
                    hex_o          = 16'd0;
                    count_o        = '0;
                    result_o.valid = 1'b1;
                    result_o.kind  = KIND_ERR;
                end else if (phase_i == PH_HEX4) begin
                    phase_o        = PH_PLAIN;
                    hex_o          = 16'd0;
                    count_o        = count_inc;
                    result_o.valid = 1'b1;
                    result_o.unit  = hex_shift;
                end else begin
                    hex_o   = hex_shift;
                    phase_o = (phase_i == PH_HEX1) ? PH_HEX2
                            : (phase_i == PH_HEX2) ? PH_HEX3 : PH_HEX4;
                end
            end
            default: begin
                // plain text
                phase_o = PH_PLAIN;
                priority if (code_unit_i == CU_QUOTE) begin
                    hex_o           = 16'd0;
                    count_o         = '0;
                    result_o.valid  = 1'b1;
                    result_o.kind   = KIND_END;
                    result_o.length = count_sat;
                end else if (code_unit_i == CU_NUL) begin
                    hex_o          = 16'd0;
                    count_o        = '0;
                    result_o.valid = 1'b1;
                    result_o.kind  = KIND_ERR;
                end else if (code_unit_i == CU_BACKSLASH) begin
                    phase_o = PH_ESC;
                end else begin
                    count_o        = count_inc;
                    result_o.valid = 1'b1;
                    result_o.unit  = code_unit_i;
                end
            end
        endcase
    end

endmodule
